// File: sv/sst_pkg.sv
// ----------------------------------------------------------------------------
// SQL subset tokenizer package
// Shared types, constants and character helpers for the tokenizer.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int MAX_TOKEN_CHARS = 32;
  localparam int LEN_W = $clog2(MAX_TOKEN_CHARS + 1);
  localparam int ADDR_W = $clog2(MAX_TOKEN_CHARS);
  localparam int KW_COUNT = 15;
  localparam int KW_CHARS = 6;
  localparam logic [30:0] NUM_LIMIT = 31'h7FFF_FFFF;

  localparam logic [3:0] K_END = 4'd0;
  localparam logic [3:0] K_SEMI = 4'd1;
  localparam logic [3:0] K_COMMA = 4'd2;
  localparam logic [3:0] K_LPAREN = 4'd3;
  localparam logic [3:0] K_RPAREN = 4'd4;
  localparam logic [3:0] K_BINOP = 4'd5;
  localparam logic [3:0] K_NUMBER = 4'd6;
  localparam logic [3:0] K_STRING = 4'd7;
  localparam logic [3:0] K_IDENT = 4'd8;
  localparam logic [3:0] K_KEYWORD = 4'd9;
  localparam logic [3:0] K_ERROR = 4'd10;

  localparam logic [30:0] ERR_BAD_CHAR = 31'd1;
  localparam logic [30:0] ERR_NUM_LONG = 31'd2;
  localparam logic [30:0] ERR_WORD_LONG = 31'd3;
  localparam logic [30:0] ERR_NO_QUOTE = 31'd4;

  localparam logic [30:0] OP_EQ = 31'd0;
  localparam logic [30:0] OP_STAR = 31'd1;

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_CHARS] = '{
    '{"S", "E", "L", "E", "C", "T"},
    '{"F", "R", "O", "M", 8'h00, 8'h00},
    '{"W", "H", "E", "R", "E", 8'h00},
    '{"I", "N", "S", "E", "R", "T"},
    '{"I", "N", "T", "O", 8'h00, 8'h00},
    '{"V", "A", "L", "U", "E", "S"},
    '{"U", "P", "D", "A", "T", "E"},
    '{"S", "E", "T", 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E"},
    '{"O", "R", "D", "E", "R", 8'h00},
    '{"B", "Y", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"A", "S", "C", 8'h00, 8'h00, 8'h00},
    '{"D", "E", "S", "C", 8'h00, 8'h00},
    '{"O", "R", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"A", "N", "D", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
    LEN_W'(6), LEN_W'(4), LEN_W'(5), LEN_W'(6), LEN_W'(4), LEN_W'(6), LEN_W'(6),
    LEN_W'(3), LEN_W'(6), LEN_W'(5), LEN_W'(2), LEN_W'(3), LEN_W'(4), LEN_W'(2),
    LEN_W'(3)
  };
  localparam logic [3:0] KW_KIND [KW_COUNT] = '{
    K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD,
    K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD, K_BINOP,
    K_BINOP
  };
  localparam logic [3:0] KW_VAL [KW_COUNT] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11,
    4'd12, 4'd2, 4'd3
  };

  typedef struct packed {
    logic [7:0] char_in;
    logic       at_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [30:0] token_value;
    logic [7:0]  text_char;
    logic        text_valid;
    logic        last_of_token;
  } out_item_t;

  typedef enum logic [1:0] {
    LM_IDLE, LM_NUM, LM_WORD, LM_STR
  } lex_mode_t;

  typedef enum logic [2:0] {
    CS_WAIT, CS_FIRST, CS_RD, CS_TX, CS_CLOSE, CS_SECOND
  } ctl_state_t;

  typedef enum logic [2:0] {
    TS_NUMBER, TS_KEYWORD, TS_ERR_NUM, TS_ERR_WORD, TS_ERR_STR, TS_TEXT,
    TS_CLOSE, TS_IDLE
  } tok_sel_t;

  typedef enum logic [3:0] {
    UP_NONE, UP_NUM_ACC, UP_WORD_PUT, UP_STR_PUT, UP_TO_IDLE, UP_START_IDENT,
    UP_START_STR, UP_TEXT_NEXT, UP_IDLE_CHAR
  } upd_t;

  typedef struct packed {
    logic     latch;
    logic     emit;
    tok_sel_t tok;
    upd_t     upd;
  } sst_cmd_t;

  typedef struct packed {
    lex_mode_t mode;
    logic      at_end;
    logic      is_digit;
    logic      is_alnum;
    logic      is_quote;
    logic      len_lt_max;
    logic      len_lt_max1;
    logic      kw_hit;
    logic      text_empty;
    logic      text_last;
    logic      kind_ident;
    logic      idle_emits;
    logic      out_free;
  } sst_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
  endfunction

endpackage

// File: sv/sst_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: sv/sst_datapath.sv
// ----------------------------------------------------------------------------
// Tokenizer datapath
// Holds the lexer state, word store, keyword match and the output register.
// ----------------------------------------------------------------------------
module sst_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  sst_pkg::in_item_t   in_data,
  input  logic                out_stall,
  input  sst_pkg::sst_cmd_t   cmd,
  output sst_pkg::sst_status_t st,
  output logic                out_valid,
  output sst_pkg::out_item_t  out_data
);
  import sst_pkg::*;

  logic [7:0]          c_r;
  logic                end_r;
  lex_mode_t           mode_r, mode_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [30:0]         acc_r, acc_nxt;
  logic [KW_COUNT-1:0] match_r, match_nxt;
  logic [LEN_W-1:0]    idx_r, idx_nxt;
  logic [LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [3:0]          kind_r, kind_nxt;
  logic                out_valid_r;
  out_item_t           out_data_r;
  out_item_t           item;
  logic [7:0]          cu;
  logic [7:0]          rdata;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [34:0]         acc_sum;
  logic                hit;
  logic [3:0]          hit_kind;
  logic [3:0]          hit_val;
  logic                c_digit, c_alpha;

  assign cu = to_upper(c_r);
  assign c_digit = is_digit(c_r);
  assign c_alpha = is_alpha(c_r);
  assign acc_sum = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {31'd0, c_r[3:0] - 4'd0};

  function automatic logic kw_pos_ok(input int k, input logic [LEN_W-1:0] pos,
                                     input logic [7:0] u);
    logic ok;
    ok = 1'b0;
    if (pos < KW_LEN[k]) begin
      ok = (KW_TEXT[k][pos[2:0]] == u);
    end
    return ok;
  endfunction

  always_comb begin
    hit = 1'b0;
    hit_kind = K_IDENT;
    hit_val = 4'd0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (match_r[k] && (len_r == KW_LEN[k])) begin
        hit = 1'b1;
        hit_kind = KW_KIND[k];
        hit_val = KW_VAL[k];
      end
    end
  end

  sst_ram #(.WIDTH(8), .DEPTH(MAX_TOKEN_CHARS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (c_r),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    we = 1'b0;
    waddr = len_r[ADDR_W-1:0];
    case (cmd.upd)
      UP_WORD_PUT, UP_STR_PUT: we = 1'b1;
      UP_IDLE_CHAR: begin
        we = !end_r && c_alpha;
        waddr = '0;
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    len_nxt = len_r;
    acc_nxt = acc_r;
    match_nxt = match_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    kind_nxt = kind_r;
    case (cmd.upd)
      UP_NUM_ACC: begin
        acc_nxt = (acc_sum > {4'd0, NUM_LIMIT}) ? NUM_LIMIT : acc_sum[30:0];
        len_nxt = len_r + LEN_W'(1);
      end
      UP_WORD_PUT: begin
        for (int k = 0; k < KW_COUNT; k++) begin
          match_nxt[k] = match_r[k] && kw_pos_ok(k, len_r, cu);
        end
        len_nxt = len_r + LEN_W'(1);
      end
      UP_STR_PUT: len_nxt = len_r + LEN_W'(1);
      UP_TO_IDLE: mode_nxt = LM_IDLE;
      UP_START_IDENT, UP_START_STR: begin
        idx_nxt = '0;
        cnt_nxt = (len_r > LEN_W'(MAX_TOKEN_CHARS - 1)) ?
                  LEN_W'(MAX_TOKEN_CHARS - 1) : len_r;
        kind_nxt = (cmd.upd == UP_START_IDENT) ? K_IDENT : K_STRING;
      end
      UP_TEXT_NEXT: idx_nxt = idx_r + LEN_W'(1);
      UP_IDLE_CHAR: begin
        mode_nxt = LM_IDLE;
        if (!end_r) begin
          if (c_r == "'") begin
            mode_nxt = LM_STR;
            len_nxt = '0;
          end else if (c_digit) begin
            mode_nxt = LM_NUM;
            acc_nxt = {27'd0, c_r[3:0]};
            len_nxt = LEN_W'(1);
          end else if (c_alpha) begin
            mode_nxt = LM_WORD;
            len_nxt = LEN_W'(1);
            for (int k = 0; k < KW_COUNT; k++) begin
              match_nxt[k] = (KW_TEXT[k][0] == cu);
            end
          end
        end
      end
      default: mode_nxt = mode_r;
    endcase
  end

  always_comb begin
    item = '0;
    item.last_of_token = 1'b1;
    case (cmd.tok)
      TS_NUMBER: begin
        item.token_kind = K_NUMBER;
        item.token_value = acc_r;
      end
      TS_KEYWORD: begin
        item.token_kind = hit_kind;
        item.token_value = {27'd0, hit_val};
      end
      TS_ERR_NUM: begin
        item.token_kind = K_ERROR;
        item.token_value = ERR_NUM_LONG;
      end
      TS_ERR_WORD: begin
        item.token_kind = K_ERROR;
        item.token_value = ERR_WORD_LONG;
      end
      TS_ERR_STR: begin
        item.token_kind = K_ERROR;
        item.token_value = ERR_NO_QUOTE;
      end
      TS_TEXT: begin
        item.token_kind = kind_r;
        item.text_char = rdata;
        item.text_valid = 1'b1;
        item.last_of_token = 1'b0;
      end
      TS_CLOSE: item.token_kind = kind_r;
      default: begin
        if (end_r) begin
          item.token_kind = K_END;
        end else begin
          case (c_r)
            ";": item.token_kind = K_SEMI;
            ",": item.token_kind = K_COMMA;
            "(": item.token_kind = K_LPAREN;
            ")": item.token_kind = K_RPAREN;
            "=": begin
              item.token_kind = K_BINOP;
              item.token_value = OP_EQ;
            end
            "*": begin
              item.token_kind = K_BINOP;
              item.token_value = OP_STAR;
            end
            default: begin
              item.token_kind = K_ERROR;
              item.token_value = ERR_BAD_CHAR;
            end
          endcase
        end
      end
    endcase
  end

  always_comb begin
    st.mode = mode_r;
    st.at_end = end_r;
    st.is_digit = c_digit;
    st.is_alnum = c_digit || c_alpha;
    st.is_quote = (c_r == "'");
    st.len_lt_max = (len_r < LEN_W'(MAX_TOKEN_CHARS));
    st.len_lt_max1 = (len_r < LEN_W'(MAX_TOKEN_CHARS - 1));
    st.kw_hit = hit;
    st.text_empty = (len_r == '0);
    st.text_last = ((idx_r + LEN_W'(1)) == cnt_r);
    st.kind_ident = (kind_r == K_IDENT);
    st.idle_emits = end_r || !((c_r == "'") || c_digit || c_alpha || is_space(c_r));
    st.out_free = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= LM_IDLE;
      len_r <= '0;
      acc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      len_r <= len_nxt;
      acc_r <= acc_nxt;
      if (st.out_free) begin
        out_valid_r <= cmd.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      c_r <= in_data.char_in;
      end_r <= in_data.at_end;
    end
    if (cmd.emit && st.out_free) begin
      out_data_r <= item;
    end
    match_r <= match_nxt;
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
    kind_r <= kind_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
endmodule

// File: sv/sst_ctrl.sv
// ----------------------------------------------------------------------------
// Tokenizer controller
// Sequences one character through finishing, text streaming and idle handling.
// ----------------------------------------------------------------------------
module sst_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  sst_pkg::sst_status_t st,
  output sst_pkg::sst_cmd_t    cmd,
  output logic                 in_stall,
  output sst_pkg::ctl_state_t  state
);
  import sst_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_WAIT: if (in_valid) state_nxt = CS_FIRST;
      CS_FIRST: begin
        case (st.mode)
          LM_NUM: begin
            if (!st.at_end && st.is_digit) begin
              if (st.len_lt_max || st.out_free) state_nxt = CS_WAIT;
            end else if (st.out_free) begin
              state_nxt = CS_SECOND;
            end
          end
          LM_WORD: begin
            if (!st.at_end && st.is_alnum) begin
              if (st.len_lt_max || st.out_free) state_nxt = CS_WAIT;
            end else if (st.kw_hit) begin
              if (st.out_free) state_nxt = CS_SECOND;
            end else begin
              state_nxt = st.text_empty ? CS_CLOSE : CS_RD;
            end
          end
          LM_STR: begin
            if (st.at_end) begin
              if (st.out_free) state_nxt = CS_WAIT;
            end else if (st.is_quote) begin
              state_nxt = st.text_empty ? CS_CLOSE : CS_RD;
            end else begin
              state_nxt = CS_WAIT;
            end
          end
          default: state_nxt = CS_SECOND;
        endcase
      end
      CS_RD: state_nxt = CS_TX;
      CS_TX: if (st.out_free) state_nxt = st.text_last ? CS_CLOSE : CS_RD;
      CS_CLOSE: if (st.out_free) state_nxt = st.kind_ident ? CS_SECOND : CS_WAIT;
      CS_SECOND: if (!st.idle_emits || st.out_free) state_nxt = CS_WAIT;
      default: state_nxt = CS_WAIT;
    endcase
  end

  always_comb begin
    cmd = '{latch: 1'b0, emit: 1'b0, tok: TS_IDLE, upd: UP_NONE};
    case (state_r)
      CS_WAIT: cmd.latch = in_valid;
      CS_FIRST: begin
        case (st.mode)
          LM_NUM: begin
            if (!st.at_end && st.is_digit) begin
              if (st.len_lt_max) begin
                cmd.upd = UP_NUM_ACC;
              end else if (st.out_free) begin
                cmd.emit = 1'b1;
                cmd.tok = TS_ERR_NUM;
                cmd.upd = UP_TO_IDLE;
              end
            end else begin
              cmd.emit = st.out_free;
              cmd.tok = TS_NUMBER;
            end
          end
          LM_WORD: begin
            if (!st.at_end && st.is_alnum) begin
              if (st.len_lt_max) begin
                cmd.upd = UP_WORD_PUT;
              end else if (st.out_free) begin
                cmd.emit = 1'b1;
                cmd.tok = TS_ERR_WORD;
                cmd.upd = UP_TO_IDLE;
              end
            end else if (st.kw_hit) begin
              cmd.emit = st.out_free;
              cmd.tok = TS_KEYWORD;
            end else begin
              cmd.upd = UP_START_IDENT;
            end
          end
          LM_STR: begin
            if (st.at_end) begin
              if (st.out_free) begin
                cmd.emit = 1'b1;
                cmd.tok = TS_ERR_STR;
                cmd.upd = UP_TO_IDLE;
              end
            end else if (st.is_quote) begin
              cmd.upd = UP_START_STR;
            end else if (st.len_lt_max1) begin
              cmd.upd = UP_STR_PUT;
            end
          end
          default: cmd.upd = UP_NONE;
        endcase
      end
      CS_TX: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.tok = TS_TEXT;
          cmd.upd = UP_TEXT_NEXT;
        end
      end
      CS_CLOSE: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.tok = TS_CLOSE;
          cmd.upd = st.kind_ident ? UP_NONE : UP_TO_IDLE;
        end
      end
      CS_SECOND: begin
        if (!st.idle_emits) begin
          cmd.upd = UP_IDLE_CHAR;
        end else if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.tok = TS_IDLE;
          cmd.upd = UP_IDLE_CHAR;
        end
      end
      default: cmd.upd = UP_NONE;
    endcase
  end

  assign in_stall = (state_r != CS_WAIT);
  assign state = state_r;
endmodule

// File: sv/sql_subset_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// SQL subset tokenizer
// Turns a stream of statement characters into SQL tokens.
// ----------------------------------------------------------------------------
// The block takes one character per transaction and works on it alone. A
// character that extends a number, word or string, or that ends in an error
// there, is done in the CS_FIRST state alone. A character handled from idle
// also passes CS_SECOND, and that includes the character that ends a number
// or word. Any single-item tokens it causes are sent from those states.
// Identifier and string text is read back from the word store one character
// at a time, through a read state and a send state for each. A stall on the
// output holds the sequence until the output register is free. The output
// register lets the next character start while the last token still waits.
module sql_subset_tokenizer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sst_pkg::out_item_t out_data
);
  import sst_pkg::*;

  sst_cmd_t    cmd;
  sst_status_t st;
  ctl_state_t  state;

  sst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall),
    .state    (state)
  );

  sst_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state == CS_FIRST))
    else $error("new character did not start processing");

  a_text_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.text_valid) |-> !out_data.last_of_token)
    else $error("text item marked as last");

  a_emit_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit) |-> st.out_free)
    else $error("token emitted into a full output register");
`endif
endmodule

// File: test/tb_sql_subset_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// SQL subset tokenizer testbench
// Drives characters into the tokenizer under random idling and stalls and
// checks every token item against a local prediction of the lexer.
// ----------------------------------------------------------------------------
module tb_sql_subset_tokenizer_unit;
  import sst_pkg::*;

  localparam int IDLE_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 170;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  sql_subset_tokenizer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  lex_mode_t mode_q;
  logic [7:0] word_q [MAX_TOKEN_CHARS];
  int unsigned len_q;
  logic [30:0] num_q;
  out_item_t token_queue [$];
  int errors;
  int items_sent;
  int tokens_seen;
  int quiet_cycles;
  bit busy_side;
  bit calm;
  bit hold_long;

  function automatic out_item_t mk(logic [3:0] k, logic [30:0] v, logic [7:0] c,
                                   logic tv, logic lt);
    out_item_t o;
    o.token_kind = k;
    o.token_value = v;
    o.text_char = c;
    o.text_valid = tv;
    o.last_of_token = lt;
    return o;
  endfunction

  function automatic bit isdig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit isalp(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic [7:0] up(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  task automatic push_text(logic [3:0] kind);
    int unsigned cnt;
    cnt = (len_q > MAX_TOKEN_CHARS - 1) ? MAX_TOKEN_CHARS - 1 : len_q;
    for (int i = 0; i < cnt; i++) token_queue.push_back(mk(kind, 0, word_q[i], 1, 0));
    token_queue.push_back(mk(kind, 0, 0, 0, 1));
  endtask

  task automatic close_word();
    string kw [15] = '{"SELECT", "FROM", "WHERE", "INSERT", "INTO", "VALUES", "UPDATE",
                       "SET", "DELETE", "ORDER", "BY", "ASC", "DESC", "OR", "AND"};
    bit same;
    for (int k = 0; k < 15; k++) begin
      same = (len_q == kw[k].len());
      for (int i = 0; same && i < len_q; i++)
        if (up(word_q[i]) != kw[k][i]) same = 0;
      if (same) begin
        if (k >= 13) token_queue.push_back(mk(K_BINOP, 31'(k - 11), 0, 0, 1));
        else token_queue.push_back(mk(K_KEYWORD, 31'(k), 0, 0, 1));
        return;
      end
    end
    push_text(K_IDENT);
  endtask

  task automatic lex_from_idle(logic fin, logic [7:0] c);
    mode_q = LM_IDLE;
    if (fin) begin
      token_queue.push_back(mk(K_END, 0, 0, 0, 1));
      return;
    end
    case (c)
      ";": token_queue.push_back(mk(K_SEMI, 0, 0, 0, 1));
      ",": token_queue.push_back(mk(K_COMMA, 0, 0, 0, 1));
      "(": token_queue.push_back(mk(K_LPAREN, 0, 0, 0, 1));
      ")": token_queue.push_back(mk(K_RPAREN, 0, 0, 0, 1));
      "=": token_queue.push_back(mk(K_BINOP, OP_EQ, 0, 0, 1));
      "*": token_queue.push_back(mk(K_BINOP, OP_STAR, 0, 0, 1));
      "'": begin
        mode_q = LM_STR;
        len_q = 0;
      end
      default: begin
        if (isdig(c)) begin
          mode_q = LM_NUM;
          num_q = 31'(c - "0");
          len_q = 1;
        end else if (isalp(c)) begin
          mode_q = LM_WORD;
          word_q[0] = c;
          len_q = 1;
        end else if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
          token_queue.push_back(mk(K_ERROR, ERR_BAD_CHAR, 0, 0, 1));
        end
      end
    endcase
  endtask

  task automatic predict_tokens(in_item_t it);
    logic [63:0] t;
    case (mode_q)
      LM_NUM: begin
        if (!it.at_end && isdig(it.char_in)) begin
          if (len_q < MAX_TOKEN_CHARS) begin
            t = num_q * 64'd10 + (it.char_in - "0");
            num_q = (t > NUM_LIMIT) ? NUM_LIMIT : t[30:0];
            len_q++;
          end else begin
            token_queue.push_back(mk(K_ERROR, ERR_NUM_LONG, 0, 0, 1));
            mode_q = LM_IDLE;
          end
        end else begin
          token_queue.push_back(mk(K_NUMBER, num_q, 0, 0, 1));
          lex_from_idle(it.at_end, it.char_in);
        end
      end
      LM_WORD: begin
        if (!it.at_end && (isalp(it.char_in) || isdig(it.char_in))) begin
          if (len_q < MAX_TOKEN_CHARS) begin
            word_q[len_q] = it.char_in;
            len_q++;
          end else begin
            token_queue.push_back(mk(K_ERROR, ERR_WORD_LONG, 0, 0, 1));
            mode_q = LM_IDLE;
          end
        end else begin
          close_word();
          lex_from_idle(it.at_end, it.char_in);
        end
      end
      LM_STR: begin
        if (it.at_end) begin
          token_queue.push_back(mk(K_ERROR, ERR_NO_QUOTE, 0, 0, 1));
          mode_q = LM_IDLE;
        end else if (it.char_in == "'") begin
          push_text(K_STRING);
          mode_q = LM_IDLE;
        end else if (len_q < MAX_TOKEN_CHARS - 1) begin
          word_q[len_q] = it.char_in;
          len_q++;
        end
      end
      default: lex_from_idle(it.at_end, it.char_in);
    endcase
  endtask

  // Directed rows: a character, the end flag, and an optional typed-in token.
  typedef struct {
    logic [7:0] ch;
    logic fin;
    bit has_exp;
    out_item_t exp;
  } row_t;
  row_t rows [$];
  out_item_t typed_queue [$];

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_long) begin
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (!busy_side) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    busy_side = 0;
    forever begin
      repeat ($urandom_range(1, 16)) @(posedge clk);
      busy_side = ~busy_side;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      out_item_t want;
      tokens_seen++;
      if (token_queue.size() == 0) begin
        $display("%0t unexpected token: expected none actual %h", $time, out_data);
        errors++;
      end else begin
        want = token_queue.pop_front();
        if (typed_queue.size() > 0 && typed_queue[0].token_kind != 4'hF) begin
          if (typed_queue[0] != want) begin
            $display("%0t table entry disagrees: expected %h actual %h", $time,
                     typed_queue[0], want);
            errors++;
          end
        end
        if (typed_queue.size() > 0) void'(typed_queue.pop_front());
        if (out_data.token_kind !== want.token_kind)
          $display("%0t token_kind: expected %0d actual %0d", $time, want.token_kind,
                   out_data.token_kind);
        if (out_data.token_value !== want.token_value)
          $display("%0t token_value: expected %0d actual %0d", $time, want.token_value,
                   out_data.token_value);
        if (out_data.text_char !== want.text_char)
          $display("%0t text_char: expected %h actual %h", $time, want.text_char,
                   out_data.text_char);
        if (out_data.text_valid !== want.text_valid)
          $display("%0t text_valid: expected %b actual %b", $time, want.text_valid,
                   out_data.text_valid);
        if (out_data.last_of_token !== want.last_of_token)
          $display("%0t last_of_token: expected %b actual %b", $time,
                   want.last_of_token, out_data.last_of_token);
        if (out_data !== want) errors++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_CYCLES) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_char(logic [7:0] ch, logic fin);
    in_item_t it;
    if (!calm && !busy_side && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    it.char_in = ch;
    it.at_end = fin;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tokens(it);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic add_row(logic [7:0] ch, logic fin, bit typed, out_item_t e);
    row_t r;
    r.ch = ch;
    r.fin = fin;
    r.has_exp = typed;
    r.exp = e;
    rows.push_back(r);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  initial begin
    string kws [15] = '{"select", "FROM", "Where", "INSERT", "into", "VALUES", "update",
                        "SET", "delete", "Order", "by", "ASC", "desc", "or", "AnD"};
    string punct = ";,()=* \t\n";
    out_item_t none;
    int pick;
    none = '0;
    none.token_kind = 4'hF;
    errors = 0;
    items_sent = 0;
    tokens_seen = 0;
    calm = 0;
    hold_long = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    mode_q = LM_IDLE;
    len_q = 0;
    num_q = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extreme bytes, punctuation, string edge cases.
    add_row(8'h00, 1'b0, 1, mk(K_ERROR, ERR_BAD_CHAR, 0, 0, 1));
    add_row(8'hFF, 1'b0, 1, mk(K_ERROR, ERR_BAD_CHAR, 0, 0, 1));
    add_row(8'h80, 1'b0, 1, mk(K_ERROR, ERR_BAD_CHAR, 0, 0, 1));
    add_row(";", 1'b0, 1, mk(K_SEMI, 0, 0, 0, 1));
    add_row(",", 1'b0, 1, mk(K_COMMA, 0, 0, 0, 1));
    add_row("(", 1'b0, 1, mk(K_LPAREN, 0, 0, 0, 1));
    add_row(")", 1'b0, 1, mk(K_RPAREN, 0, 0, 0, 1));
    add_row("=", 1'b0, 1, mk(K_BINOP, OP_EQ, 0, 0, 1));
    add_row("*", 1'b0, 1, mk(K_BINOP, OP_STAR, 0, 0, 1));
    add_row(" ", 1'b0, 0, none);
    add_row(8'h0D, 1'b0, 0, none);
    add_row(8'h09, 1'b0, 0, none);
    add_row(8'h00, 1'b1, 1, mk(K_END, 0, 0, 0, 1));
    add_row("'", 1'b0, 0, none);
    add_row(8'h00, 1'b0, 0, none);
    add_row(8'hFF, 1'b0, 0, none);
    add_row("'", 1'b0, 0, none);
    add_row("'", 1'b0, 0, none);
    add_row("x", 1'b1, 1, mk(K_ERROR, ERR_NO_QUOTE, 0, 0, 1));
    add_row("7", 1'b0, 0, none);
    add_row(8'hFF, 1'b1, 0, none);
    foreach (rows[i]) begin
      send_char(rows[i].ch, rows[i].fin);
      while (typed_queue.size() < token_queue.size())
        typed_queue.push_back(rows[i].has_exp ? rows[i].exp : none);
    end

    // Keywords in mixed case, long numbers and words, saturation, long strings.
    foreach (kws[i]) begin
      send_text(kws[i]);
      send_char(" ", 1'b0);
    end
    send_text("99999999999999999999999999999999");
    send_char("9", 1'b0);
    send_text("2147483647 2147483648 0 ");
    send_text("abcdefghijklmnopqrstuvwxyz0123456");
    send_text("Zq9 ");
    send_char("'", 1'b0);
    for (int i = 0; i < 40; i++) send_char(8'($urandom_range(0, 255)) | 8'h80, 1'b0);
    send_char("'", 1'b0);

    // Long receiver hold while the sender keeps offering characters.
    hold_long = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_long = 0;
      end
      send_text("select a1,b2 from t where x='hello' or y=42 and z=7;");
    join
    in_valid <= 1'b0;
    wait (token_queue.size() == 0);
    repeat (80) @(posedge clk);

    // Random part: mostly statement-shaped token sequences, some raw noise.
    for (int n = 0; n < RANDOM_ITEMS; ) begin
      if (n > RANDOM_ITEMS - 60) calm = 1;
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1: begin
          send_text(kws[$urandom_range(0, 14)]);
          n += 3;
        end
        2, 3: begin
          send_char(rand_letter(), 1'b0);
          for (int k = $urandom_range(0, $urandom_range(0, 1) ? 4 : 36); k > 0; k--) begin
            send_char($urandom_range(0, 2) ? rand_letter() : 8'($urandom_range("0", "9")), 1'b0);
            n++;
          end
          n++;
        end
        4: begin
          for (int k = $urandom_range(1, $urandom_range(0, 3) ? 5 : 36); k > 0; k--) begin
            send_char(8'($urandom_range("0", "9")), 1'b0);
            n++;
          end
        end
        5: begin
          send_char("'", 1'b0);
          for (int k = $urandom_range(0, $urandom_range(0, 3) ? 6 : 40); k > 0; k--) begin
            send_char(8'($urandom_range(0, 255)) == "'" ? 8'h27 ^ 8'h40 :
                      8'($urandom_range(0, 255)), 1'b0);
            n++;
          end
          if ($urandom_range(0, 7) != 0) send_char("'", 1'b0);
          n += 2;
        end
        6, 7: begin
          send_char(punct[$urandom_range(0, punct.len() - 1)], 1'b0);
          n++;
        end
        8: begin
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
          n++;
        end
        default: begin
          send_char(" ", 1'b0);
          n++;
        end
      endcase
    end
    send_char(8'h00, 1'b1);
    in_valid <= 1'b0;
    calm = 1;
    wait (token_queue.size() == 0);
    repeat (100) @(posedge clk);

    $display("Sent %0d characters and checked %0d token items: punctuation, keywords,",
             items_sent, tokens_seen);
    $display("identifiers, numbers, strings, overflow and error cases.");
    if (errors == 0 && token_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
